// ===== hdl/tt_pkg.sv =====
// ----------------------------------------------------------------------------
// tt_pkg - shared types and constants for the transposition table
// Field widths, stream packing offsets, command and bound codes, and the
// records that pass between the front and back parts.
// ----------------------------------------------------------------------------
package tt_pkg;

    localparam int TT_IDX_W   = 16;
    localparam int TT_ENTRIES = 1 << TT_IDX_W;

    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 8;
    localparam int SCORE_W = 21;
    localparam int BOUND_W = 2;

    // stream packing, lowest bit first
    localparam int KEY_LO    = 0;
    localparam int DEPTH_LO  = KEY_LO + KEY_W;
    localparam int ALPHA_LO  = DEPTH_LO + DEPTH_W;
    localparam int BETA_LO   = ALPHA_LO + SCORE_W;
    localparam int SCORE_LO  = BETA_LO + SCORE_W;
    localparam int BOUND_LO  = SCORE_LO + SCORE_W;
    localparam int S_FIELD_W = BOUND_LO + BOUND_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SCORE_W + 7) / 8) * 8;

    localparam logic signed [SCORE_W-1:0] MISS_SCORE = -21'sd1000000;

    localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
    localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd1;
    localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd2;

    typedef enum logic {
        CMD_PROBE = 1'b0,
        CMD_STORE = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [KEY_W-1:0]    key;
        logic [DEPTH_W-1:0]  depth;
        logic [SCORE_W-1:0]  alpha;
        logic [SCORE_W-1:0]  beta;
        logic [SCORE_W-1:0]  score;
        logic [BOUND_W-1:0]  bound;
    } tt_op_t;

    // full key kept: a cleared slot holds key 0 whatever its index
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [DEPTH_W-1:0]  depth;
        logic [SCORE_W-1:0]  score;
        logic [BOUND_W-1:0]  bound;
    } tt_entry_t;

    // back part -> front part
    typedef struct packed {
        logic clear_done;
        logic pop;
    } tt_ctl_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_EVAL
    } tt_state_t;

endpackage

// ===== hdl/tt_front.sv =====
// ----------------------------------------------------------------------------
// tt_front - input side of the transposition table
// Takes beats from the input stream, decodes them into operation records
// and holds them in a two-entry queue for the back part.
// ----------------------------------------------------------------------------
module tt_front import tt_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,
    input  tt_ctl_t              ctl,
    output logic                 head_valid,
    output tt_op_t               head_op
);

    tt_op_t     q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    tt_op_t     in_op;
    logic       push;
    logic       pop;

    always_comb begin
        in_op.cmd   = cmd_t'(s_tuser[0]);
        in_op.key   = s_tdata[KEY_LO   +: KEY_W];
        in_op.depth = s_tdata[DEPTH_LO +: DEPTH_W];
        in_op.alpha = s_tdata[ALPHA_LO +: SCORE_W];
        in_op.beta  = s_tdata[BETA_LO  +: SCORE_W];
        in_op.score = s_tdata[SCORE_LO +: SCORE_W];
        in_op.bound = s_tdata[BOUND_LO +: BOUND_W];
    end

    assign s_tready   = ctl.clear_done && (count_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign head_valid = (count_reg != 2'd0);
    assign pop        = ctl.pop && head_valid;
    assign head_op    = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

// ===== hdl/tt_back.sv =====
// ----------------------------------------------------------------------------
// tt_back - table store, lookup and result register
// Clears the table after reset, then runs one queued operation at a time:
// a store writes its slot, a probe reads it and evaluates the bound.
// ----------------------------------------------------------------------------
module tt_back import tt_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  tt_op_t               head_op,
    output tt_ctl_t              ctl,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [0:0]           m_tuser
);

    tt_entry_t mem [TT_ENTRIES];

    tt_state_t             state_reg, state_next;
    logic [TT_IDX_W-1:0]   clr_cnt_reg, clr_cnt_next;
    tt_op_t                cur_reg;
    tt_entry_t             rd_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_hit_reg;
    logic [SCORE_W-1:0]    out_score_reg;

    logic                  pop;
    logic                  mem_we;
    logic                  mem_re;
    logic                  load_out;
    logic                  can_load;
    logic [TT_IDX_W-1:0]   cur_idx;
    logic [TT_IDX_W-1:0]   wr_addr;
    tt_entry_t             wr_data;
    logic                  hit_c;
    logic [SCORE_W-1:0]    score_c;
    logic                  key_match;

    assign cur_idx  = cur_reg.key[TT_IDX_W-1:0];
    assign can_load = !out_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == '1) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (head_valid) begin
                    state_next = (head_op.cmd == CMD_STORE) ? ST_WRITE : ST_READ;
                end
            end
            ST_WRITE: state_next = ST_IDLE;
            ST_READ:  state_next = ST_EVAL;
            ST_EVAL: begin
                if (can_load) state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        pop      = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_CLEAR: mem_we   = 1'b1;
            ST_IDLE:  pop      = head_valid;
            ST_WRITE: mem_we   = 1'b1;
            ST_READ:  mem_re   = 1'b1;
            ST_EVAL:  load_out = can_load;
            default:  ;
        endcase
    end

    assign ctl.pop        = pop;
    assign ctl.clear_done = (state_reg != ST_CLEAR);

    assign clr_cnt_next = clr_cnt_reg + 1'b1;

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end else begin
            wr_addr       = cur_idx;
            wr_data.key   = cur_reg.key;
            wr_data.depth = cur_reg.depth;
            wr_data.score = cur_reg.score;
            wr_data.bound = cur_reg.bound;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            rd_reg <= mem[cur_idx];
        end
    end

    // bound evaluation on the registered slot
    assign key_match = (rd_reg.key == cur_reg.key)
                    && (rd_reg.depth >= cur_reg.depth);

    always_comb begin
        hit_c   = 1'b0;
        score_c = MISS_SCORE;
        priority if (!key_match) begin
            hit_c = 1'b0;
        end else if (rd_reg.bound == BOUND_EXACT) begin
            hit_c   = 1'b1;
            score_c = rd_reg.score;
        end else if (rd_reg.bound == BOUND_UPPER
                     && $signed(rd_reg.score) <= $signed(cur_reg.alpha)) begin
            hit_c   = 1'b1;
            score_c = cur_reg.alpha;
        end else if (rd_reg.bound == BOUND_LOWER
                     && $signed(rd_reg.score) >= $signed(cur_reg.beta)) begin
            hit_c   = 1'b1;
            score_c = cur_reg.beta;
        end else begin
            hit_c = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= head_op;
        end
        if (load_out) begin
            out_hit_reg   <= hit_c;
            out_score_reg <= score_c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - SCORE_W){1'b0}}, out_score_reg};
    assign m_tuser  = out_hit_reg;

endmodule

// ===== hdl/transposition_table_probe_store.sv =====
// ----------------------------------------------------------------------------
// transposition_table_probe_store - direct-mapped search result table
// Always-replace table of search results, probed and written over a stream.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole table to zero, one slot a cycle,
// and s_tready stays low for that time. The slot is the low 16 bits of the
// key. A store beat overwrites its slot and gives no result beat; a probe
// beat gives exactly one result beat, m_tuser[0] set on a hit and m_tdata
// holding the score (-1000000 on a miss). Beats are taken into a two-entry
// queue, and the table side works on one queued beat at a time through its
// single-port memory: a store is popped and then written, a probe is popped,
// read from the table and then bound-checked, and the next beat is popped
// only after the last one is done. A stalled result register holds the
// table side, not the queue, so beats keep being taken while a result waits
// until the queue is full.
// ----------------------------------------------------------------------------
module transposition_table_probe_store import tt_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // key, depth, alpha, beta, score, bound_kind; zero padding on top
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // result_score; zero padding on top
    output logic [M_TDATA_W-1:0] m_tdata,
    // hit
    output logic [0:0]           m_tuser
);

    tt_ctl_t ctl;
    logic    head_valid;
    tt_op_t  head_op;

    // accept side and queue
    tt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .ctl        (ctl),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    // table, lookup and result register
    tt_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_op    (head_op),
        .ctl        (ctl),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

// ===== hdl/tt_checker.sv =====
// ----------------------------------------------------------------------------
// tt_checker - port-level checks for the transposition table
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module tt_checker import tt_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [0:0]           m_tuser
);

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // reset empties the output and starts the clearing sweep
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("output or input live straight after reset");

    // a miss carries the sentinel score and zero padding
    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |->
            m_tdata == {{(M_TDATA_W - SCORE_W){1'b0}}, MISS_SCORE})
        else $error("miss without sentinel score");

    // an offered result beat is fully defined
    a_out_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !$isunknown({m_tdata, m_tuser}))
        else $error("result beat carries unknown bits");

endmodule

bind transposition_table_probe_store tt_checker u_tt_checker (.*);
